>>> rtl/ehc_pkg.sv
// ehc_pkg: shared types and constants of the Ethernet header classifier.
// Used by every module of the block; depends on nothing.
package ehc_pkg;

  // Ethertypes and IPv4 protocol numbers
  localparam logic [15:0] TYPE_IPV4  = 16'h0800;
  localparam logic [15:0] TYPE_ARP   = 16'h0806;
  localparam logic [7:0]  PROTO_ICMP = 8'h01;
  localparam logic [7:0]  PROTO_TCP  = 8'h06;
  localparam logic [7:0]  PROTO_UDP  = 8'h11;

  // Result class codes
  localparam logic [2:0] CLASS_ARP  = 3'd0;
  localparam logic [2:0] CLASS_ICMP = 3'd1;
  localparam logic [2:0] CLASS_TCP  = 3'd2;
  localparam logic [2:0] CLASS_UDP  = 3'd3;
  localparam logic [2:0] CLASS_DNS  = 3'd4;

  localparam logic [15:0] DNS_PORT_RESET = 16'd53;

  // Byte offsets; the transport header sits after a 20-byte IPv4 header
  localparam logic [5:0] TRANSPORT_AT = 6'd34;
  localparam logic [5:0] POS_LAST     = 6'd63;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       frame_end;
  } in_beat_t;

  typedef struct packed {
    logic [2:0]  packet_class;
    logic [15:0] source_port;
    logic [15:0] dest_port;
    logic [5:0]  flag_bits;
    logic [31:0] sequence_value;
    logic [31:0] acknowledge_value;
    logic [15:0] window_value;
    logic [15:0] length_value;
    logic [15:0] arp_operation;
    logic [31:0] arp_sender_ip;
    logic [31:0] arp_target_ip;
    logic [47:0] arp_sender_mac;
  } out_beat_t;

  // Per-frame capture state
  typedef struct packed {
    logic [5:0]  byte_position;
    logic [15:0] ether_kind;
    logic [7:0]  ip_protocol;
    logic [3:0]  ip_header_words;
    logic [15:0] ip_total_length;
    logic [31:0] port_pair;
    logic [31:0] seq_register;
    logic [31:0] ack_register;
    logic [3:0]  data_offset_words;
    logic [5:0]  flag_register;
    logic [15:0] window_or_udp_length;
    logic [63:0] arp_lo;   // bytes 20-27
    logic [63:0] arp_hi;   // bytes 28-31 then 38-41
  } frame_fields_t;

  // Status of the input register toward the classifier
  typedef struct packed {
    logic valid;
    logic last;
  } pend_t;

endpackage

>>> rtl/ehc_capture.sv
// ehc_capture: input register and per-frame field registers.
// Depends on ehc_pkg.
module ehc_capture (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  load,
  input  ehc_pkg::in_beat_t     beat,
  input  logic                  advance,
  output ehc_pkg::pend_t        pend,
  output ehc_pkg::frame_fields_t fields_next
);

  logic                   hold_valid;
  ehc_pkg::in_beat_t      hold;
  ehc_pkg::frame_fields_t fields;

  assign pend.valid = hold_valid;
  assign pend.last  = hold.frame_end;

  always_comb begin
    logic [5:0] p;
    logic [7:0] b;
    p = fields.byte_position;
    b = hold.data_byte;
    fields_next = fields;
    if (p == 6'd12 || p == 6'd13) begin
      fields_next.ether_kind = {fields.ether_kind[7:0], b};
    end
    if (p == 6'd14) begin
      fields_next.ip_header_words = b[3:0];
    end
    if (p == 6'd16 || p == 6'd17) begin
      fields_next.ip_total_length = {fields.ip_total_length[7:0], b};
    end
    if (p == 6'd23) begin
      fields_next.ip_protocol = b;
    end
    if (p >= 6'd20 && p <= 6'd27) begin
      fields_next.arp_lo = {fields.arp_lo[55:0], b};
    end
    if ((p >= 6'd28 && p <= 6'd31) || (p >= 6'd38 && p <= 6'd41)) begin
      fields_next.arp_hi = {fields.arp_hi[55:0], b};
    end
    if (p >= ehc_pkg::TRANSPORT_AT && p <= ehc_pkg::TRANSPORT_AT + 6'd3) begin
      fields_next.port_pair = {fields.port_pair[23:0], b};
    end
    if (p >= 6'd38 && p <= 6'd41) begin
      fields_next.seq_register = {fields.seq_register[23:0], b};
    end
    if (p >= 6'd42 && p <= 6'd45) begin
      fields_next.ack_register = {fields.ack_register[23:0], b};
    end
    if (p == 6'd46) begin
      fields_next.data_offset_words = b[7:4];
    end
    if (p == 6'd47) begin
      fields_next.flag_register = b[5:0];
    end
    // protocol byte (23) is already settled when these offsets come by
    if (fields.ip_protocol == ehc_pkg::PROTO_UDP) begin
      if (p == 6'd38 || p == 6'd39) begin
        fields_next.window_or_udp_length = {fields.window_or_udp_length[7:0], b};
      end
    end else begin
      if (p == 6'd48 || p == 6'd49) begin
        fields_next.window_or_udp_length = {fields.window_or_udp_length[7:0], b};
      end
    end
    if (p != ehc_pkg::POS_LAST) begin
      fields_next.byte_position = p + 6'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
      fields     <= '0;
    end else begin
      if (load) begin
        hold_valid <= 1'b1;
      end else if (advance) begin
        hold_valid <= 1'b0;
      end
      if (advance) begin
        fields <= hold.frame_end ? '0 : fields_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      hold <= beat;
    end
  end

endmodule

>>> rtl/ehc_classify.sv
// ehc_classify: frame classification and the result register.
// Depends on ehc_pkg.
module ehc_classify (
  input  logic                   clk,
  input  logic                   rst,
  input  ehc_pkg::frame_fields_t fields_next,
  input  logic [15:0]            dns_port,
  input  logic                   take,
  input  logic                   out_stall,
  output logic                   out_free,
  output logic                   out_valid,
  output ehc_pkg::out_beat_t     out_data
);

  ehc_pkg::out_beat_t res;
  logic               hit;

  always_comb begin
    logic [15:0] src;
    logic [15:0] dst;
    logic [6:0]  hdr_bytes;
    src = fields_next.port_pair[31:16];
    dst = fields_next.port_pair[15:0];
    hdr_bytes = {1'b0, fields_next.ip_header_words, 2'b00}
              + {1'b0, fields_next.data_offset_words, 2'b00};
    res = '0;
    hit = 1'b0;
    if (fields_next.ether_kind == ehc_pkg::TYPE_ARP) begin
      hit                = 1'b1;
      res.packet_class   = ehc_pkg::CLASS_ARP;
      res.arp_operation  = fields_next.arp_lo[63:48];
      res.arp_sender_mac = fields_next.arp_lo[47:0];
      res.arp_sender_ip  = fields_next.arp_hi[63:32];
      res.arp_target_ip  = fields_next.arp_hi[31:0];
    end else if (fields_next.ether_kind == ehc_pkg::TYPE_IPV4) begin
      priority if (fields_next.ip_protocol == ehc_pkg::PROTO_ICMP) begin
        hit              = 1'b1;
        res.packet_class = ehc_pkg::CLASS_ICMP;
      end else if (fields_next.ip_protocol == ehc_pkg::PROTO_TCP) begin
        hit                   = 1'b1;
        res.packet_class      = ehc_pkg::CLASS_TCP;
        res.source_port       = src;
        res.dest_port         = dst;
        res.flag_bits         = fields_next.flag_register;
        res.sequence_value    = fields_next.seq_register;
        res.acknowledge_value = fields_next.ack_register;
        res.window_value      = fields_next.window_or_udp_length;
        // payload clamps at zero when headers claim more than the total
        res.length_value = (fields_next.ip_total_length < {9'd0, hdr_bytes}) ? 16'd0 :
                           fields_next.ip_total_length - {9'd0, hdr_bytes};
      end else if (fields_next.ip_protocol == ehc_pkg::PROTO_UDP) begin
        hit              = 1'b1;
        res.packet_class = (src == dns_port || dst == dns_port) ?
                           ehc_pkg::CLASS_DNS : ehc_pkg::CLASS_UDP;
        res.source_port  = src;
        res.dest_port    = dst;
        res.length_value = fields_next.window_or_udp_length;
      end else begin
        hit = 1'b0;
      end
    end
  end

  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= hit;
    end else if (out_free) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_data <= res;
    end
  end

endmodule

>>> rtl/ethernet_header_classifier.sv
// ethernet_header_classifier: top level of the Ethernet header classifier.
// Depends on ehc_pkg, ehc_capture and ehc_classify.
//
//   channel  | handshake                    | payload
//   ---------+------------------------------+-------------------------------
//   in       | in_valid / in_stall          | in_data  (byte, frame_end)
//   out      | out_valid / out_stall        | out_data (at most one per frame)
//   cfg      | cfg_wr_en                    | cfg_wr_data (dns_port)
//
// A byte beat is taken into the input register and then captured into the
// field registers; on the frame's last byte the class is decided from the
// held byte and the field registers and lands in the result register in the
// same cycle as that capture. One byte per cycle is sustained unless out_stall
// holds the result register when a frame's last byte arrives.
// Reset (rst, synchronous) clears all field registers and sets dns_port to 53.
// in_stall rises only while the last byte of a frame waits for a result
// register still held by out_stall; other bytes keep flowing.
module ethernet_header_classifier (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  ehc_pkg::in_beat_t   in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output ehc_pkg::out_beat_t  out_data,
  input  logic                cfg_wr_en,
  input  logic [15:0]         cfg_wr_data
);

  logic [15:0]            dns_port_reg;
  ehc_pkg::pend_t         pend;
  ehc_pkg::frame_fields_t fields_next;
  logic                   out_free;
  logic                   advance;
  logic                   load;
  logic                   take;

  // the held beat moves on unless it ends a frame and the result slot is busy
  assign advance  = pend.valid && (!pend.last || out_free);
  assign in_stall = pend.valid && !advance;
  assign load     = in_valid && !in_stall;
  assign take     = advance && pend.last;

  always_ff @(posedge clk) begin
    if (rst) begin
      dns_port_reg <= ehc_pkg::DNS_PORT_RESET;
    end else if (cfg_wr_en) begin
      dns_port_reg <= cfg_wr_data;
    end
  end

  ehc_capture u_capture (
    .clk         (clk),
    .rst         (rst),
    .load        (load),
    .beat        (in_data),
    .advance     (advance),
    .pend        (pend),
    .fields_next (fields_next)
  );

  ehc_classify u_classify (
    .clk         (clk),
    .rst         (rst),
    .fields_next (fields_next),
    .dns_port    (dns_port_reg),
    .take        (take),
    .out_stall   (out_stall),
    .out_free    (out_free),
    .out_valid   (out_valid),
    .out_data    (out_data)
  );

endmodule

>>> rtl/ehc_checker.sv
// ehc_checker: port-level checks of the Ethernet header classifier.
// Depends on ehc_pkg; bound to ethernet_header_classifier below.
module ehc_checker (
  input logic               clk,
  input logic               rst,
  input logic               out_valid,
  input logic               out_stall,
  input ehc_pkg::out_beat_t out_data
);

  // a result beat held by stall stays put
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  // nothing comes out right after reset
  a_reset_quiet: assert property (@(posedge clk) $past(rst) |-> !out_valid)
    else $error("result valid right after reset");

  // TCP-only fields stay zero for every other class
  a_tcp_only: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.packet_class != ehc_pkg::CLASS_TCP |->
      out_data.flag_bits == 6'd0 && out_data.sequence_value == 32'd0 &&
      out_data.acknowledge_value == 32'd0 && out_data.window_value == 16'd0)
    else $error("TCP field set on non-TCP result");

  // ARP fields only on ARP; ports and length never on ARP or ICMP
  a_arp_only: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.packet_class != ehc_pkg::CLASS_ARP |->
      out_data.arp_operation == 16'd0 && out_data.arp_sender_mac == 48'd0 &&
      out_data.arp_sender_ip == 32'd0 && out_data.arp_target_ip == 32'd0)
    else $error("ARP field set on non-ARP result");

  a_no_ports: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.packet_class == ehc_pkg::CLASS_ARP ||
                  out_data.packet_class == ehc_pkg::CLASS_ICMP) |->
      out_data.source_port == 16'd0 && out_data.dest_port == 16'd0 &&
      out_data.length_value == 16'd0)
    else $error("port or length set on ARP or ICMP result");

endmodule

bind ethernet_header_classifier ehc_checker u_ehc_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
